### rtl/bmqe_pkg.sv
package bmqe_pkg;

    localparam int MAX_SIZE_DEF = 64;
    localparam int SIZE_W       = 7;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1FFF;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_WRITE     = 3'd1,
        OP_READ      = 3'd2,
        OP_COUNT     = 3'd3,
        OP_MAX_ROW   = 3'd4,
        OP_MAX_CHILD = 3'd5,
        OP_ROOT      = 3'd6,
        OP_ZERO_ROW  = 3'd7
    } t_op;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture the transaction and clear accumulators
        logic clr;     // write a zero row at the scan address
        logic wr;      // read-modify-write finishes at the captured row
        logic rd;      // unused; the RAM read port always follows the scan address
        logic acc;     // fold in the registered read data
        logic first;   // accumulator pass takes the row of the captured node
    } t_cmd;

    typedef struct packed {
        logic last;    // scan address is at the final row in use
    } t_sts;

endpackage

### rtl/bmqe_ram.sv
module bmqe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/bmqe_datapath.sv
module bmqe_datapath import bmqe_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [2:0]        i_op,
    input  logic [IDX_W-1:0]  i_row,
    input  logic [IDX_W-1:0]  i_col,
    input  logic              i_bit,
    input  logic [$clog2(MAX_SIZE)-1:0] i_addr,
    input  logic [$clog2(MAX_SIZE)-1:0] i_addr_d,
    output t_sts              o_sts,
    output logic [IDX_W-1:0]  o_index,
    output logic              o_index_valid,
    output logic [CNT_W-1:0]  o_bit_count,
    output logic              o_answer_flag
);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int PW = $clog2(MAX_SIZE + 1);
    localparam int NW = (SIZE_W > PW) ? SIZE_W : PW;

    logic [NW-1:0] n_use;
    logic [MAX_SIZE-1:0] colmask, rdata, wdata, masked;
    logic [PW-1:0] pop;
    logic [IDX_W-1:0] r_row, r_col;
    logic r_bit, r_rin, r_cin;
    t_op r_op;
    logic [MAX_SIZE-1:0] r_node;   // row of the queried node, in-range columns only
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic r_valid, r_colhit;
    logic [PW-1:0] r_pop;
    logic r_pop_v;
    logic [AW-1:0] r_pop_a;
    logic we;
    logic [AW-1:0] waddr;

    assign n_use = (NW'(i_size) > NW'(MAX_SIZE)) ? NW'(MAX_SIZE) : NW'(i_size);
    always_comb begin
        for (int i = 0; i < MAX_SIZE; i++) begin
            colmask[i] = (NW'(i) < n_use);
        end
    end
    assign o_sts.last = (NW'(i_addr) + NW'(1) >= n_use);

    bmqe_ram #(.WIDTH(MAX_SIZE), .DEPTH(MAX_SIZE)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(i_addr),
        .o_rdata(rdata)
    );

    assign masked = rdata & colmask;
    // Population count is a row-wide adder tree; it is registered before use.
    always_comb begin
        pop = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            pop = pop + PW'(masked[i]);
        end
    end

    always_comb begin
        wdata = rdata;
        wdata[AW'(r_col)] = r_bit;
        if (i_cmd.clr) begin
            wdata = '0;
        end
    end
    assign we    = i_cmd.clr || (i_cmd.wr && r_rin && r_cin);
    assign waddr = i_cmd.clr ? i_addr : AW'(r_row);

    always_ff @(posedge i_clk) begin
        r_pop   <= pop;
        r_pop_v <= i_cmd.acc;
        r_pop_a <= i_addr_d;
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_row    <= i_row;
            r_col    <= i_col;
            r_bit    <= i_bit;
            r_rin    <= (NW'(i_row) < n_use);
            r_cin    <= (NW'(i_col) < n_use);
            r_cnt    <= '0;
            r_idx    <= '0;
            r_valid  <= 1'b0;
            r_colhit <= 1'b0;
            r_node   <= '0;
        end else begin
            if (i_cmd.first) begin
                r_node <= masked;
            end
            if (i_cmd.acc && masked[AW'(r_row)]) begin
                r_colhit <= 1'b1;
            end
            if (r_pop_v) begin
                unique case (r_op)
                    OP_COUNT: begin
                        if ({1'b0, r_cnt} + (CNT_W+1)'(r_pop) > (CNT_W+1)'(COUNT_MAX)) begin
                            r_cnt <= COUNT_MAX;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(r_pop);
                        end
                    end
                    OP_MAX_ROW: begin
                        if (CNT_W'(r_pop) > r_cnt) begin
                            r_cnt   <= CNT_W'(r_pop);
                            r_idx   <= IDX_W'(r_pop_a);
                            r_valid <= 1'b1;
                        end
                    end
                    OP_MAX_CHILD: begin
                        if (r_rin && r_node[r_pop_a] && CNT_W'(r_pop) >= r_cnt) begin
                            r_cnt   <= CNT_W'(r_pop);
                            r_idx   <= IDX_W'(r_pop_a);
                            r_valid <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_index       = '0;
        o_index_valid = 1'b0;
        o_bit_count   = '0;
        o_answer_flag = 1'b0;
        unique case (r_op)
            OP_READ:      o_answer_flag = r_rin && r_cin && r_node[AW'(r_col)];
            OP_COUNT:     o_bit_count = r_cnt;
            OP_MAX_ROW, OP_MAX_CHILD: begin
                o_index       = r_idx;
                o_index_valid = r_valid;
                o_bit_count   = r_cnt;
            end
            OP_ROOT:      o_answer_flag = r_rin && !r_colhit && (r_node != '0);
            OP_ZERO_ROW:  o_answer_flag = !r_rin || (r_node == '0);
            default: ;
        endcase
    end
endmodule

### rtl/bmqe_ctrl.sv
module bmqe_ctrl import bmqe_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_op,
    input  logic [IDX_W-1:0] i_row,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output logic       o_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd,
    output logic [$clog2(MAX_SIZE)-1:0] o_addr,
    output logic [$clog2(MAX_SIZE)-1:0] o_addr_d
);
    localparam int AW = $clog2(MAX_SIZE);

    typedef enum logic [2:0] {
        S_IDLE, S_NODE, S_SCAN, S_DRAIN, S_CLEAR, S_WRITE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr, r_addr_d;
    logic [1:0] r_drain, n_drain;
    logic r_out_valid, n_out_valid;
    logic acc_q;
    t_op op;

    assign op = t_op'(i_op);
    assign o_ready = (r_state == S_IDLE) && !r_out_valid;

    always_comb begin
        n_state = r_state;
        n_addr = r_addr;
        n_drain = r_drain;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        acc_q = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_addr = '0;
                    unique case (op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_WRITE: begin
                            n_addr = AW'(i_row);
                            n_state = S_WRITE;
                        end
                        OP_COUNT, OP_MAX_ROW: n_state = S_SCAN;
                        default: begin
                            n_addr = AW'(i_row);
                            n_state = S_NODE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(MAX_SIZE - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                // Read is in flight; next cycle finishes the update.
                n_state = S_DRAIN;
                n_drain = 2'd3;
            end
            S_NODE: begin
                n_addr = '0;
                n_drain = 2'd0;
                n_state = S_DRAIN;
            end
            S_SCAN: begin
                acc_q = 1'b1;
                n_addr = r_addr + AW'(1);
                if (i_sts.last) begin
                    n_addr = r_addr;
                    n_drain = 2'd1;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                unique case (r_drain)
                    2'd0: begin
                        // Node row is on the RAM output now.
                        o_cmd.first = 1'b1;
                        n_state = S_SCAN;
                    end
                    2'd1: begin
                        o_cmd.acc = 1'b1;
                        n_drain = 2'd2;
                    end
                    2'd2: n_state = S_DONE;
                    default: begin
                        o_cmd.wr = 1'b1;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SCAN && r_addr != '0) begin
            o_cmd.acc = 1'b1;
        end
        if (r_state == S_SCAN && r_addr == '0 && acc_q) begin
            o_cmd.acc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr <= '0;
            r_drain <= '0;
            r_out_valid <= 1'b0;
            r_addr_d <= '0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_drain <= n_drain;
            r_out_valid <= n_out_valid;
            r_addr_d <= r_addr;
        end
    end

    assign o_addr = r_addr;
    assign o_addr_d = r_addr_d;
    assign o_out_valid = r_out_valid;
endmodule

### rtl/bit_matrix_query_engine_top.sv
// One transaction is processed at a time; the scan of one RAM row per cycle
// through a single read port sets the rate.
// Reset (synchronous, active low) loads matrix_size 64 and clears the matrix by
// a pass over all MAX_SIZE rows, during which no input transaction is accepted.
module bit_matrix_query_engine_top import bmqe_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operation[2:0], row[8:3], col[14:9], bit_value[15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // index[5:0], index_valid[6], bit_count[19:7],
                                       // answer_flag[20], zero[23:21]
);
    localparam int AW = $clog2(MAX_SIZE);

    logic [SIZE_W-1:0] r_size;
    logic r_init;
    logic [AW-1:0] r_iaddr;
    t_cmd cmd, cmd_dp;
    t_sts sts;
    logic [AW-1:0] addr, addr_d;
    logic ready_c;
    logic [IDX_W-1:0] idx;
    logic vld, flag;
    logic [CNT_W-1:0] cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(64);
            r_init <= 1'b1;
            r_iaddr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (r_init) begin
                r_iaddr <= r_iaddr + AW'(1);
                if (r_iaddr == AW'(MAX_SIZE - 1)) begin
                    r_init <= 1'b0;
                end
            end
        end
    end

    bmqe_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid && !r_init),
        .i_op       (s_axis_tdata[2:0]),
        .i_row      (s_axis_tdata[8:3]),
        .i_out_ready(m_axis_tready),
        .i_sts      (sts),
        .o_ready    (ready_c),
        .o_out_valid(m_axis_tvalid),
        .o_cmd      (cmd),
        .o_addr     (addr),
        .o_addr_d   (addr_d)
    );

    always_comb begin
        cmd_dp = cmd;
        if (r_init) begin
            cmd_dp.clr = 1'b1;
        end
    end

    bmqe_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd_dp),
        .i_size       (r_size),
        .i_op         (s_axis_tdata[2:0]),
        .i_row        (s_axis_tdata[8:3]),
        .i_col        (s_axis_tdata[14:9]),
        .i_bit        (s_axis_tdata[15]),
        .i_addr       (r_init ? r_iaddr : addr),
        .i_addr_d     (addr_d),
        .o_sts        (sts),
        .o_index      (idx),
        .o_index_valid(vld),
        .o_bit_count  (cnt),
        .o_answer_flag(flag)
    );

    assign s_axis_tready = ready_c && !r_init;
    assign m_axis_tdata  = {3'b000, flag, cnt, vld, idx};
endmodule
